/* rtl/ppf_pkg.sv */
// Shared types and constants for the packed pixel fill engine.
// Holds configuration and job types, operation and register codes.
// Used by the top level, the front end and the back end; depends on nothing.
package ppf_pkg;

    // default limits of the frame store
    localparam int MAX_WIDTH           = 256;
    localparam int MAX_HEIGHT          = 256;
    localparam int MAX_BYTES_PER_PIXEL = 4;
    localparam int QUEUE_DEPTH         = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd2;

    // command codes
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_HLINE = 3'd2;
    localparam logic [2:0] OP_VLINE = 3'd3;
    localparam logic [2:0] OP_RECT  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    // job kinds handed from front to back
    localparam logic [1:0] JOB_NONE = 2'd0;
    localparam logic [1:0] JOB_READ = 2'd1;
    localparam logic [1:0] JOB_FILL = 2'd2;

    typedef struct packed {
        logic [8:0] frame_width;
        logic [8:0] frame_height;
        logic [2:0] bytes_per_pixel;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  cols;
        logic [8:0]  rows;
        logic [31:0] color;
        logic        clip;
    } t_job;

endpackage

/* rtl/packed_pixel_fill_engine.sv */
// Top level of the packed pixel fill engine: configuration registers and queues.
// Depends on ppf_pkg, ppf_fifo, ppf_front and ppf_back.
//
// Usage:
//   Configuration: write frame_width (index 0), frame_height (1) and
//   bytes_per_pixel (2) through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
//   Values saturate into range; zero acts as one.
//   Commands: present a command and raise push; it is taken when full is low.
//   Results: one per command, oldest first, on o_pixel_value/o_clipped while
//   empty is low; take it with pop.
// Sequencing:
//   The front end captures a command, forms the pixel index, then forms the
//   byte address and hands the job off (capture, index multiply, address
//   multiply and hand-off); it takes no new command until the hand-off. The
//   back end moves one byte a cycle: a read runs its read states and B_RDLAST,
//   a fill writes each byte, and every job, skipped or not, ends in B_RESULT.
// Reset: the queues empty and the registers return to 256 x 256 x 4 bytes;
//   the frame store is not cleared.
// Stall: a full result queue holds the back end, the job queue then fills and
//   full stays high until pop frees room.
module packed_pixel_fill_engine #(
    parameter int MAX_WIDTH           = ppf_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT          = ppf_pkg::MAX_HEIGHT,
    parameter int MAX_BYTES_PER_PIXEL = ppf_pkg::MAX_BYTES_PER_PIXEL,
    parameter int QUEUE_DEPTH         = ppf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [8:0]  i_span_w,
    input  logic [8:0]  i_span_h,
    input  logic [31:0] i_color,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_pixel_value,
    output logic        o_clipped
);
    localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT * MAX_BYTES_PER_PIXEL;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int JOB_W       = $bits(ppf_pkg::t_job) + ADDR_W;
    localparam int RES_W       = 33;

    localparam logic [8:0] RST_WIDTH  = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [8:0] RST_HEIGHT = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
    localparam logic [2:0] RST_BPP    =
        3'((MAX_BYTES_PER_PIXEL < 4) ? MAX_BYTES_PER_PIXEL : 4);

    ppf_pkg::t_cfg     r_cfg;
    logic [8:0]        n_width;
    logic [8:0]        n_height;
    logic [2:0]        n_bpp;

    logic              front_push;
    logic              jq_full;
    ppf_pkg::t_job     front_job;
    logic [ADDR_W-1:0] front_addr;
    logic              jq_empty;
    logic              jq_pop;
    logic [JOB_W-1:0]  jq_data;
    ppf_pkg::t_job     back_job;
    logic [ADDR_W-1:0] back_addr;
    logic              res_push;
    logic              rq_full;
    logic [31:0]       res_value;
    logic              res_clip;
    logic [RES_W-1:0]  rq_data;

    // saturate written values into their ranges
    always_comb begin
        n_width = i_cfg_data;
        if (i_cfg_data == 9'd0) begin
            n_width = 9'd1;
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            n_width = 9'(MAX_WIDTH);
        end
        n_height = i_cfg_data;
        if (i_cfg_data == 9'd0) begin
            n_height = 9'd1;
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            n_height = 9'(MAX_HEIGHT);
        end
        n_bpp = i_cfg_data[2:0];
        if (i_cfg_data[2:0] == 3'd0) begin
            n_bpp = 3'd1;
        end else if (32'(i_cfg_data[2:0]) > MAX_BYTES_PER_PIXEL) begin
            n_bpp = 3'(MAX_BYTES_PER_PIXEL);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= RST_WIDTH;
            r_cfg.frame_height    <= RST_HEIGHT;
            r_cfg.bytes_per_pixel <= RST_BPP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppf_pkg::CFG_FRAME_WIDTH:     r_cfg.frame_width     <= n_width;
                ppf_pkg::CFG_FRAME_HEIGHT:    r_cfg.frame_height    <= n_height;
                ppf_pkg::CFG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= n_bpp;
                default: ;
            endcase
        end
    end

    ppf_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_op       (i_op),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_span_w   (i_span_w),
        .i_span_h   (i_span_h),
        .i_color    (i_color),
        .o_job_push (front_push),
        .i_job_full (jq_full),
        .o_job      (front_job),
        .o_job_addr (front_addr)
    );

    ppf_fifo #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_full  (jq_full),
        .i_data  ({front_addr, front_job}),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_data  (jq_data)
    );

    assign back_job  = jq_data[$bits(ppf_pkg::t_job)-1:0];
    assign back_addr = jq_data[JOB_W-1:$bits(ppf_pkg::t_job)];

    ppf_back #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (jq_empty),
        .o_job_pop   (jq_pop),
        .i_job       (back_job),
        .i_job_addr  (back_addr),
        .o_res_push  (res_push),
        .i_res_full  (rq_full),
        .o_res_value (res_value),
        .o_res_clip  (res_clip)
    );

    ppf_fifo #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (rq_full),
        .i_data  ({res_value, res_clip}),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rq_data)
    );

    assign o_pixel_value = rq_data[RES_W-1:1];
    assign o_clipped     = rq_data[0];

endmodule

/* rtl/ppf_fifo.sv */
// Small show-ahead queue built from registers.
// Used between the front and back ends and for results; depends on nothing.
module ppf_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/ppf_front.sv */
// Front end: accepts commands, clips them to the frame, computes start address.
// Depends on ppf_pkg for the configuration and job types and the codes.
module ppf_front #(
    parameter int ADDR_W = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppf_pkg::t_cfg      i_cfg,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_pos_x,
    input  logic [7:0]         i_pos_y,
    input  logic [8:0]         i_span_w,
    input  logic [8:0]         i_span_h,
    input  logic [31:0]        i_color,
    output logic               o_job_push,
    input  logic               i_job_full,
    output ppf_pkg::t_job      o_job,
    output logic [ADDR_W-1:0]  o_job_addr
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state;
    logic [2:0]  r_op;
    logic [7:0]  r_px;
    logic [7:0]  r_py;
    logic [8:0]  r_sw;
    logic [8:0]  r_sh;
    logic [31:0] r_color;
    logic [17:0] r_lin;

    logic [8:0]  ew;
    logic [8:0]  eh;
    logic [9:0]  xend;
    logic [9:0]  yend;
    logic        clip_x;
    logic        clip_y;
    logic        in_x;
    logic        in_y;
    logic [8:0]  xlim;
    logic [8:0]  ylim;
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [20:0] byte_full;

    assign o_full     = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

    // hold the command, then form the linear pixel index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_op    <= i_op;
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_sw    <= i_span_w;
                        r_sh    <= i_span_h;
                        r_color <= i_color;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_lin   <= ({10'b0, r_py} * {9'b0, i_cfg.frame_width}) + {10'b0, r_px};
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_job_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // effective span per command
    always_comb begin
        case (r_op)
            ppf_pkg::OP_WRITE: begin ew = 9'd1;  eh = 9'd1; end
            ppf_pkg::OP_HLINE: begin ew = r_sw;  eh = 9'd1; end
            ppf_pkg::OP_VLINE: begin ew = 9'd1;  eh = r_sh; end
            ppf_pkg::OP_RECT:  begin ew = r_sw;  eh = r_sh; end
            default:           begin ew = 9'd0;  eh = 9'd0; end
        endcase
    end

    // clip the span against the frame edges
    assign xend   = {2'b0, r_px} + {1'b0, ew};
    assign yend   = {2'b0, r_py} + {1'b0, eh};
    assign clip_x = (xend > {1'b0, i_cfg.frame_width});
    assign clip_y = (yend > {1'b0, i_cfg.frame_height});
    assign in_x   = ({1'b0, r_px} < i_cfg.frame_width);
    assign in_y   = ({1'b0, r_py} < i_cfg.frame_height);
    assign xlim   = clip_x ? i_cfg.frame_width : xend[8:0];
    assign ylim   = clip_y ? i_cfg.frame_height : yend[8:0];
    assign cols   = xlim - {1'b0, r_px};
    assign rows   = ylim - {1'b0, r_py};

    assign byte_full = {3'b0, r_lin} * {18'b0, i_cfg.bytes_per_pixel};

    // classify into a job for the back end
    always_comb begin
        o_job.color = r_color;
        o_job.cols  = cols;
        o_job.rows  = rows;
        o_job.kind  = ppf_pkg::JOB_NONE;
        o_job.clip  = 1'b0;
        o_job_addr  = ADDR_W'(byte_full);
        case (r_op)
            ppf_pkg::OP_READ: begin
                o_job.cols = 9'd1;
                o_job.rows = 9'd1;
                o_job.kind = (in_x && in_y) ? ppf_pkg::JOB_READ : ppf_pkg::JOB_NONE;
                o_job.clip = !(in_x && in_y);
            end
            ppf_pkg::OP_WRITE, ppf_pkg::OP_HLINE, ppf_pkg::OP_VLINE, ppf_pkg::OP_RECT: begin
                if (ew != 9'd0 && eh != 9'd0) begin
                    o_job.clip = clip_x || clip_y;
                    o_job.kind = (in_x && in_y) ? ppf_pkg::JOB_FILL : ppf_pkg::JOB_NONE;
                end
            end
            ppf_pkg::OP_CLEAR: begin
                o_job.kind = ppf_pkg::JOB_FILL;
                o_job.cols = i_cfg.frame_width;
                o_job.rows = i_cfg.frame_height;
                o_job_addr = '0;
            end
            default: begin
                o_job.kind = ppf_pkg::JOB_NONE;
            end
        endcase
    end

endmodule

/* rtl/ppf_back.sv */
// Back end: carries out jobs on the byte-wide frame store, one byte a cycle.
// Depends on ppf_pkg for the configuration and job types and the job kinds.
module ppf_back #(
    parameter int STORE_BYTES = 262144,
    parameter int ADDR_W      = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppf_pkg::t_cfg      i_cfg,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    input  ppf_pkg::t_job      i_job,
    input  logic [ADDR_W-1:0]  i_job_addr,
    output logic               o_res_push,
    input  logic               i_res_full,
    output logic [31:0]        o_res_value,
    output logic               o_res_clip
);
    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_READ   = 3'd1;
    localparam logic [2:0] B_RDLAST = 3'd2;
    localparam logic [2:0] B_FILL   = 3'd3;
    localparam logic [2:0] B_RESULT = 3'd4;

    logic [7:0]        r_mem [STORE_BYTES];
    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_row_base;
    logic [1:0]        r_bi;
    logic [8:0]        r_col;
    logic [8:0]        r_row;
    logic [8:0]        r_cols;
    logic [31:0]       r_color;
    logic              r_clip;
    logic [31:0]       r_val;
    logic [7:0]        r_rdata;
    logic              r_rd_pend;
    logic [1:0]        r_rd_idx;

    logic [11:0]       stride;
    logic [ADDR_W-1:0] next_row;
    logic              last_byte;
    logic              mem_we;
    logic [7:0]        wbyte;

    assign stride    = {3'b0, i_cfg.frame_width} * {9'b0, i_cfg.bytes_per_pixel};
    assign next_row  = r_row_base + ADDR_W'(stride);
    assign last_byte = ({1'b0, r_bi} == (i_cfg.bytes_per_pixel - 3'd1));
    assign mem_we    = (r_state == B_FILL);

    assign o_job_pop   = (r_state == B_IDLE) && !i_job_empty;
    assign o_res_push  = (r_state == B_RESULT) && !i_res_full;
    assign o_res_value = r_val;
    assign o_res_clip  = r_clip;

    // select the byte of the color; three-byte pixels go high byte first
    always_comb begin
        if (i_cfg.bytes_per_pixel == 3'd3) begin
            case (r_bi)
                2'd0:    wbyte = r_color[23:16];
                2'd1:    wbyte = r_color[15:8];
                default: wbyte = r_color[7:0];
            endcase
        end else begin
            wbyte = r_color[{r_bi, 3'b000} +: 8];
        end
    end

    // frame store: one write or read port, registered read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= wbyte;
        end
        r_rdata <= r_mem[r_addr];
    end

    // sequence jobs byte by byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == B_READ);
            r_rd_idx  <= r_bi;
            // merge the byte that came back from the store
            if (r_rd_pend) begin
                if (i_cfg.bytes_per_pixel == 3'd3) begin
                    r_val <= {r_val[23:0], r_rdata};
                end else begin
                    r_val[{r_rd_idx, 3'b000} +: 8] <= r_rdata;
                end
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_addr     <= i_job_addr;
                        r_row_base <= i_job_addr;
                        r_col      <= i_job.cols;
                        r_cols     <= i_job.cols;
                        r_row      <= i_job.rows;
                        r_color    <= i_job.color;
                        r_clip     <= i_job.clip;
                        r_bi       <= 2'd0;
                        r_val      <= 32'd0;
                        case (i_job.kind)
                            ppf_pkg::JOB_READ: r_state <= B_READ;
                            ppf_pkg::JOB_FILL: r_state <= B_FILL;
                            default:           r_state <= B_RESULT;
                        endcase
                    end
                end
                B_READ: begin
                    r_bi   <= r_bi + 2'd1;
                    r_addr <= r_addr + ADDR_W'(1);
                    if (last_byte) begin
                        r_state <= B_RDLAST;
                    end
                end
                B_RDLAST: begin
                    r_state <= B_RESULT;
                end
                B_FILL: begin
                    if (last_byte) begin
                        r_bi <= 2'd0;
                        if (r_col == 9'd1) begin
                            if (r_row == 9'd1) begin
                                r_state <= B_RESULT;
                            end else begin
                                r_row      <= r_row - 9'd1;
                                r_col      <= r_cols;
                                r_row_base <= next_row;
                                r_addr     <= next_row;
                            end
                        end else begin
                            r_col  <= r_col - 9'd1;
                            r_addr <= r_addr + ADDR_W'(1);
                        end
                    end else begin
                        r_bi   <= r_bi + 2'd1;
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                B_RESULT: begin
                    if (!i_res_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_byte_in_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL) |-> ({1'b0, r_bi} < i_cfg.bytes_per_pixel))
        else $error("fill byte index beyond pixel depth");
    a_last_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RDLAST) |-> r_rd_pend)
        else $error("last read byte not in flight");
    a_fill_counts_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL) |-> (r_col != 9'd0 && r_row != 9'd0))
        else $error("fill running with an empty span");
    a_fill_addr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL) |-> (32'(r_addr) < STORE_BYTES))
        else $error("fill address beyond frame store");
`endif

endmodule

/* tb/tb_packed_pixel_fill_engine.sv */
// Self-checking testbench for packed_pixel_fill_engine: pixel reads, writes, lines,
// rectangles and clears over several frame shapes, checked against a private frame store.
// Depends on ppf_pkg and the RTL under rtl.
module tb_packed_pixel_fill_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES   = ppf_pkg::MAX_WIDTH * ppf_pkg::MAX_HEIGHT *
                                   ppf_pkg::MAX_BYTES_PER_PIXEL;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int NUM_SHAPES    = 7;
    localparam int DRAIN_CYCLES  = 16;
    // a full clear of the largest frame writes 262144 bytes with nothing accepted meanwhile
    localparam int STALL_LIMIT   = 800000;

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [8:0]  span_w;
        logic [8:0]  span_h;
        logic [31:0] color;
    } t_fill_cmd;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        clipped;
    } t_fill_result;

    // Frame store mirror plus the queue of results still owed by the block.
    class frame_predictor;
        int unsigned  width;
        int unsigned  height;
        int unsigned  depth;
        logic [7:0]   store [STORE_BYTES];
        t_fill_result owed_results [$];
        int           errors;

        function new();
            width  = ppf_pkg::MAX_WIDTH;
            height = ppf_pkg::MAX_HEIGHT;
            depth  = ppf_pkg::MAX_BYTES_PER_PIXEL;
            errors = 0;
        endfunction

        // zero acts as one, anything above the limit acts as the limit
        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_register(logic [1:0] idx, logic [8:0] data);
            case (idx)
                ppf_pkg::CFG_FRAME_WIDTH:
                    width  = clamp(data, ppf_pkg::MAX_WIDTH);
                ppf_pkg::CFG_FRAME_HEIGHT:
                    height = clamp(data, ppf_pkg::MAX_HEIGHT);
                ppf_pkg::CFG_BYTES_PER_PIXEL:
                    depth  = clamp(data[2:0], ppf_pkg::MAX_BYTES_PER_PIXEL);
                default: ;
            endcase
        endfunction

        function int unsigned byte_addr(int unsigned x, int unsigned y);
            return (y * width + x) * depth;
        endfunction

        // three-byte pixels go high byte first, the rest little-endian
        function void paint(int unsigned x, int unsigned y, logic [31:0] c);
            int unsigned a;
            int          k;
            a = byte_addr(x, y);
            if (depth == 3) begin
                store[a]     = c[23:16];
                store[a + 1] = c[15:8];
                store[a + 2] = c[7:0];
            end else begin
                for (k = 0; k < int'(depth); k++) store[a + k] = c[8*k +: 8];
            end
        endfunction

        function logic [31:0] fetch(int unsigned x, int unsigned y);
            int unsigned a;
            logic [31:0] v;
            int          k;
            a = byte_addr(x, y);
            v = '0;
            if (depth == 3) begin
                v = {8'h00, store[a], store[a + 1], store[a + 2]};
            end else begin
                for (k = 0; k < int'(depth); k++) v[8*k +: 8] = store[a + k];
            end
            return v;
        endfunction

        // paint the in-frame part of a block, flag any part past the edges
        function logic block_fill(int unsigned x0, int unsigned y0, int unsigned w,
                                  int unsigned h, logic [31:0] c);
            int unsigned x;
            int unsigned y;
            if (w == 0 || h == 0) return 1'b0;
            for (y = y0; y < y0 + h && y < height; y++)
                for (x = x0; x < x0 + w && x < width; x++) paint(x, y, c);
            return (x0 + w > width) || (y0 + h > height);
        endfunction

        function void note_command(t_fill_cmd cmd);
            t_fill_result r;
            r = '0;
            case (cmd.op)
                ppf_pkg::OP_READ: begin
                    if (cmd.pos_x < width && cmd.pos_y < height)
                        r.pixel_value = fetch(cmd.pos_x, cmd.pos_y);
                    else
                        r.clipped = 1'b1;
                end
                ppf_pkg::OP_WRITE:
                    r.clipped = block_fill(cmd.pos_x, cmd.pos_y, 1, 1, cmd.color);
                ppf_pkg::OP_HLINE:
                    r.clipped = block_fill(cmd.pos_x, cmd.pos_y, cmd.span_w, 1, cmd.color);
                ppf_pkg::OP_VLINE:
                    r.clipped = block_fill(cmd.pos_x, cmd.pos_y, 1, cmd.span_h, cmd.color);
                ppf_pkg::OP_RECT:
                    r.clipped = block_fill(cmd.pos_x, cmd.pos_y, cmd.span_w,
                                           cmd.span_h, cmd.color);
                ppf_pkg::OP_CLEAR:
                    void'(block_fill(0, 0, width, height, cmd.color));
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [31:0] value, logic clip);
            t_fill_result e;
            if (owed_results.size() == 0) begin
                $error("result beat with no command pending: pixel_value %h clipped %b",
                       value, clip);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (value !== e.pixel_value) begin
                $error("pixel_value: expected %h, actual %h", e.pixel_value, value);
                errors++;
            end
            if (clip !== e.clipped) begin
                $error("clipped: expected %b, actual %b", e.clipped, clip);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [8:0]  i_cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  i_op;
    logic [7:0]  i_pos_x;
    logic [7:0]  i_pos_y;
    logic [8:0]  i_span_w;
    logic [8:0]  i_span_h;
    logic [31:0] i_color;
    logic        empty;
    logic        pop;
    logic [31:0] o_pixel_value;
    logic        o_clipped;

    frame_predictor model;

    packed_pixel_fill_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_w      (i_span_w),
        .i_span_h      (i_span_h),
        .i_color       (i_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_value (o_pixel_value),
        .o_clipped     (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_fill_cmd make_cmd(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                           logic [8:0] w, logic [8:0] h, logic [31:0] c);
        t_fill_cmd cmd;
        cmd.op     = op;
        cmd.pos_x  = x;
        cmd.pos_y  = y;
        cmd.span_w = w;
        cmd.span_h = h;
        cmd.color  = c;
        return cmd;
    endfunction

    // mostly inside the frame, sometimes anywhere in the field
    function automatic logic [7:0] random_pos(int unsigned limit);
        if ($urandom_range(0, 4) == 0) return 8'($urandom);
        return 8'($urandom_range(0, limit - 1));
    endfunction

    // mostly short spans, some zero, some up to the frame edge, a few over the field
    function automatic logic [8:0] random_span(int unsigned limit);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 9'd0;
        if (pick < 80) return 9'($urandom_range(1, 8));
        if (pick < 95) return 9'($urandom_range(1, limit));
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic t_fill_cmd random_cmd();
        t_fill_cmd   cmd;
        int unsigned pick;
        cmd.pos_x  = random_pos(model.width);
        cmd.pos_y  = random_pos(model.height);
        cmd.span_w = random_span(model.width);
        cmd.span_h = random_span(model.height);
        cmd.color  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd.op = ppf_pkg::OP_READ;
        else if (pick < 50) cmd.op = ppf_pkg::OP_WRITE;
        else if (pick < 62) cmd.op = ppf_pkg::OP_HLINE;
        else if (pick < 74) cmd.op = ppf_pkg::OP_VLINE;
        else if (pick < 88) cmd.op = ppf_pkg::OP_RECT;
        else if (pick < 94) cmd.op = ppf_pkg::OP_CLEAR;
        else if (pick < 97) cmd.op = OP_SPARE_LO;
        else                cmd.op = OP_SPARE_HI;
        return cmd;
    endfunction

    // Present one command and hold it until the block takes the beat.
    task automatic send_cmd(input t_fill_cmd cmd);
        push     <= 1'b1;
        i_op     <= cmd.op;
        i_pos_x  <= cmd.pos_x;
        i_pos_y  <= cmd.pos_y;
        i_span_w <= cmd.span_w;
        i_span_h <= cmd.span_h;
        i_color  <= cmd.color;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        model.note_command(cmd);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles > 0) begin
            push <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every owed result come out, then let the block settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model.set_register(idx, data);
    endtask

    // Result side: own stall pattern, changing between eager, random and sluggish.
    initial begin : result_sink
        int unsigned mode;
        int unsigned left;
        mode = 0;
        left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) model.check_result(o_pixel_value, o_clipped);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Abort when no beat moves on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [8:0]  shape_w   [NUM_SHAPES];
        logic [8:0]  shape_h   [NUM_SHAPES];
        logic [8:0]  shape_bpp [NUM_SHAPES];
        int          s;
        int          n;
        int          burst;
        int          per_shape;

        model = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= ppf_pkg::CFG_FRAME_WIDTH;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_op       <= ppf_pkg::OP_READ;
        i_pos_x    <= '0;
        i_pos_y    <= '0;
        i_span_w   <= '0;
        i_span_h   <= '0;
        i_color    <= '0;

        // raw register values: zeros, over-range values, ignored high bits
        shape_w[0] = 9'd0;   shape_h[0] = 9'd0;   shape_bpp[0] = 9'd0;
        shape_w[1] = 9'h1ff; shape_h[1] = 9'd3;   shape_bpp[1] = 9'd7;
        shape_w[2] = 9'd17;  shape_h[2] = 9'd300; shape_bpp[2] = 9'd3;
        shape_w[3] = 9'd40;  shape_h[3] = 9'd24;  shape_bpp[3] = 9'h1fa;
        shape_w[4] = 9'd5;   shape_h[4] = 9'd9;   shape_bpp[4] = 9'd2;
        for (s = 5; s < NUM_SHAPES; s++) begin
            shape_w[s]   = 9'($urandom_range(1, 40));
            shape_h[s]   = 9'($urandom_range(1, 40));
            shape_bpp[s] = 9'($urandom_range(1, 4));
        end
        per_shape = RANDOM_ITEMS / NUM_SHAPES;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset shape, 256 x 256 x 4: clear first so every read hits written bytes.
        send_cmd(make_cmd(ppf_pkg::OP_CLEAR, 8'd9,   8'd9,   9'd3,   9'd3,   32'h5a3c_96e1));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd0,   8'd0,   9'd0,   9'd0,   32'h0));
        send_cmd(make_cmd(ppf_pkg::OP_WRITE, 8'd255, 8'd255, 9'd0,   9'd0,   32'hffff_ffff));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd255, 8'd255, 9'h1ff, 9'h1ff, 32'hffff_ffff));
        send_cmd(make_cmd(ppf_pkg::OP_WRITE, 8'd0,   8'd0,   9'd0,   9'd0,   32'h0));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd0,   8'd0,   9'd0,   9'd0,   32'h0));
        // lines running past the right and bottom edges
        send_cmd(make_cmd(ppf_pkg::OP_HLINE, 8'd200, 8'd7,   9'h1ff, 9'd0,   32'h0102_0304));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd255, 8'd7,   9'd0,   9'd0,   32'h0));
        send_cmd(make_cmd(ppf_pkg::OP_VLINE, 8'd3,   8'd250, 9'd0,   9'd256, 32'hc0de_0bad));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd3,   8'd255, 9'd0,   9'd0,   32'h0));
        // zero spans write nothing
        send_cmd(make_cmd(ppf_pkg::OP_RECT,  8'd10,  8'd10,  9'd0,   9'd5,   32'h1111_1111));
        send_cmd(make_cmd(ppf_pkg::OP_RECT,  8'd10,  8'd10,  9'd3,   9'd0,   32'h2222_2222));
        send_cmd(make_cmd(ppf_pkg::OP_HLINE, 8'd10,  8'd10,  9'd0,   9'd0,   32'h3333_3333));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd10,  8'd10,  9'd0,   9'd0,   32'h0));
        send_cmd(make_cmd(ppf_pkg::OP_RECT,  8'd254, 8'd254, 9'd2,   9'd2,   32'h8765_4321));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd255, 8'd255, 9'd0,   9'd0,   32'h0));
        send_cmd(make_cmd(OP_SPARE_LO,       8'd1,   8'd1,   9'd1,   9'd1,   32'hdead_beef));
        send_cmd(make_cmd(OP_SPARE_HI,       8'd255, 8'd255, 9'h1ff, 9'h1ff, 32'hffff_ffff));
        send_cmd(make_cmd(ppf_pkg::OP_HLINE, 8'd0,   8'd0,   9'd256, 9'd0,   32'h00ff_00ff));
        send_cmd(make_cmd(ppf_pkg::OP_READ,  8'd128, 8'd0,   9'd0,   9'd0,   32'h0));

        for (s = 0; s < NUM_SHAPES; s++) begin
            // reprogram only while nothing is in flight; the spare index must be ignored
            wait_drained();
            write_reg(ppf_pkg::CFG_FRAME_WIDTH, shape_w[s]);
            write_reg(CFG_SPARE, 9'($urandom));
            write_reg(ppf_pkg::CFG_FRAME_HEIGHT, shape_h[s]);
            write_reg(ppf_pkg::CFG_BYTES_PER_PIXEL, shape_bpp[s]);
            i_cfg_we <= 1'b0;

            // clear the new layout, then probe its corners and just past its edges
            send_cmd(make_cmd(ppf_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 9'($urandom),
                              9'($urandom), $urandom));
            send_cmd(make_cmd(ppf_pkg::OP_READ, 8'd0, 8'd0, 9'd0, 9'd0, 32'h0));
            send_cmd(make_cmd(ppf_pkg::OP_READ, 8'(model.width - 1), 8'(model.height - 1),
                              9'd0, 9'd0, 32'h0));
            if (model.width < ppf_pkg::MAX_WIDTH)
                send_cmd(make_cmd(ppf_pkg::OP_READ, 8'(model.width), 8'd0, 9'd0, 9'd0,
                                  32'h0));
            if (model.height < ppf_pkg::MAX_HEIGHT)
                send_cmd(make_cmd(ppf_pkg::OP_WRITE, 8'd0, 8'(model.height), 9'd0, 9'd0,
                                  $urandom));

            // random bursts with gaps; now and then hold off until the block drains
            n = 0;
            while (n < per_shape) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && n < per_shape) begin
                    send_cmd(random_cmd());
                    n++;
                    burst--;
                end
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                else if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 8));
            end
        end

        wait_drained();
        if (model.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* packed_pixel_fill_engine.f */
rtl/ppf_pkg.sv
rtl/ppf_fifo.sv
rtl/ppf_front.sv
rtl/ppf_back.sv
rtl/packed_pixel_fill_engine.sv
tb/tb_packed_pixel_fill_engine.sv
